>>> rtl/lzrle_pkg.sv
// shared constants and types of the lzss/rle block decompressor
// used by lzrle_parser and lzss_rle_block_decompressor; no dependencies
`timescale 1ns / 1ps

package lzrle_pkg;

   // history window and derived widths
   localparam int WINDOW_DEPTH = 4096;
   localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
   localparam int PROD_W       = $clog2(WINDOW_DEPTH + 1);

   // stream format constants
   localparam int OFFSET_W     = 12;
   localparam int COPY_LEN_W   = 5;
   localparam int REPEAT_W     = 13;
   localparam int COPY_BIAS    = 3;
   localparam int RUN_BIAS     = 16;
   localparam int GROUP_SIZE   = 16;

   // what one accepted byte asks the history side to do
   typedef enum logic [1:0] {
      TOK_NONE = 2'd0,
      TOK_LIT  = 2'd1,
      TOK_COPY = 2'd2,
      TOK_RLE  = 2'd3
   } token_kind_type;

   typedef struct packed {
      token_kind_type           kind;
      logic [7:0]               value;
      logic [OFFSET_W-1:0]      offset;
      logic [COPY_LEN_W-1:0]    copy_len;
      logic [REPEAT_W-1:0]      run_len;
   } token_type;

endpackage

>>> rtl/lzrle_parser.sv
// flag word and token parser of the lzss/rle decompressor
// depends on lzrle_pkg; turns each accepted byte into a token command
`timescale 1ns / 1ps

module lzrle_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                block_end,
   output lzrle_pkg::token_type token
);

   typedef enum logic [6:0] {
      M_FLAG_HI  = 7'b0000001,
      M_FLAG_LO  = 7'b0000010,
      M_LITRUN   = 7'b0000100,
      M_TOKEN    = 7'b0001000,
      M_TOK2     = 7'b0010000,
      M_RLE_CNT  = 7'b0100000,
      M_RLE_FILL = 7'b1000000
   } mode_type;

   mode_type     mode_ff, mode_in;
   logic [15:0]  flag_ff, flag_in;
   logic [4:0]   flags_left_ff, flags_left_in;
   logic [4:0]   lit_left_ff, lit_left_in;
   logic [23:0]  hold_ff, hold_in;

   logic [4:0]   flags_dec;
   logic [4:0]   lit_dec;
   mode_type     after_flag;
   logic [15:0]  flag_lo;
   logic [11:0]  tok_offset;

   // helpers for advancing to the next flag and counting literals
   assign flags_dec  = flags_left_ff - {4'd0, (flags_left_ff != 5'd0)};
   assign lit_dec    = lit_left_ff - {4'd0, (lit_left_ff != 5'd0)};
   assign after_flag = (flags_dec == 5'd0) ? M_FLAG_HI : M_TOKEN;
   assign flag_lo    = {flag_ff[15:8], data_byte};
   assign tok_offset = {hold_ff[7:0], data_byte[7:4]};

   // next parse state and token for the current byte
   always_comb begin
      mode_in       = mode_ff;
      flag_in       = flag_ff;
      flags_left_in = flags_left_ff;
      lit_left_in   = lit_left_ff;
      hold_in       = hold_ff;
      token.kind     = lzrle_pkg::TOK_NONE;
      token.value    = data_byte;
      token.offset   = tok_offset;
      token.copy_len = 5'({1'b0, data_byte[3:0]} + 5'(lzrle_pkg::COPY_BIAS));
      token.run_len  = 13'({1'b0, hold_ff[11:0]} + 13'(lzrle_pkg::RUN_BIAS));
      unique case (mode_ff)
         M_FLAG_HI: begin
            flag_in = {data_byte, 8'h00};
            mode_in = M_FLAG_LO;
         end
         M_FLAG_LO: begin
            flag_in = flag_lo;
            if (flag_lo == 16'd0) begin
               lit_left_in = 5'(lzrle_pkg::GROUP_SIZE);
               mode_in     = M_LITRUN;
            end else begin
               flags_left_in = 5'(lzrle_pkg::GROUP_SIZE);
               mode_in       = M_TOKEN;
            end
         end
         M_LITRUN: begin
            token.kind  = lzrle_pkg::TOK_LIT;
            lit_left_in = lit_dec;
            if (lit_dec == 5'd0) mode_in = M_FLAG_HI;
         end
         M_TOKEN: begin
            if (flag_ff[15]) begin
               hold_in = {16'd0, data_byte};
               mode_in = M_TOK2;
            end else begin
               token.kind    = lzrle_pkg::TOK_LIT;
               flag_in       = {flag_ff[14:0], 1'b0};
               flags_left_in = flags_dec;
               mode_in       = after_flag;
            end
         end
         M_TOK2: begin
            hold_in = {hold_ff[15:0], data_byte};
            if (tok_offset == 12'd0) begin
               mode_in = M_RLE_CNT;
            end else begin
               token.kind    = lzrle_pkg::TOK_COPY;
               flag_in       = {flag_ff[14:0], 1'b0};
               flags_left_in = flags_dec;
               mode_in       = after_flag;
            end
         end
         M_RLE_CNT: begin
            hold_in = {hold_ff[15:0], data_byte};
            mode_in = M_RLE_FILL;
         end
         M_RLE_FILL: begin
            token.kind    = lzrle_pkg::TOK_RLE;
            flag_in       = {flag_ff[14:0], 1'b0};
            flags_left_in = flags_dec;
            mode_in       = after_flag;
         end
         default: begin
            mode_in = M_FLAG_HI;
         end
      endcase
      // block end drops any partial token and restarts parsing
      if (block_end) begin
         mode_in       = M_FLAG_HI;
         flag_in       = 16'd0;
         flags_left_in = 5'd0;
         lit_left_in   = 5'd0;
         hold_in       = 24'd0;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_FLAG_HI;
         flag_ff       <= 16'd0;
         flags_left_ff <= 5'd0;
         lit_left_ff   <= 5'd0;
         hold_ff       <= 24'd0;
      end else if (take) begin
         mode_ff       <= mode_in;
         flag_ff       <= flag_in;
         flags_left_ff <= flags_left_in;
         lit_left_ff   <= lit_left_in;
         hold_ff       <= hold_in;
      end
   end

   // a group count is only live while tokens are parsed
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_TOKEN) |-> (flags_left_ff != 5'd0))
      else $error("token mode with no flags left");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_LITRUN) |-> (lit_left_ff != 5'd0))
      else $error("literal run mode with no literals left");

   assert property (@(posedge clock) disable iff (reset)
      (take && block_end) |=> (mode_ff == M_FLAG_HI))
      else $error("parser not restarted after block end");

endmodule

>>> rtl/lzss_rle_block_decompressor.sv
// top level of the lzss/rle block decompressor: history memory and copy sequencer
// depends on lzrle_pkg and lzrle_parser
`timescale 1ns / 1ps

// Usage
// req channel: one compressed byte per transaction (req_data_byte), with
//   req_block_end high on the last byte of a block. A transaction completes
//   at a rising edge with req_valid high and req_stall low.
// rsp channel: decoded results (rsp_out_byte, rsp_repeat_res, rsp_run_last,
//   rsp_block_done, rsp_bad_reference) under the same valid/stall rule.
// Timing
//   literal, bad reference, end marker: the result is registered
//     and appears on rsp the cycle after the byte is taken
//   history copy of len+3 bytes: per byte a history read, then write
//     back and emit, which waits while rsp is stalled
//   rle run of n bytes: result out the cycle after the take, then n bytes of
//     history fill before the next byte is taken; a run on the last byte skips it
//   header and token bytes that give no result: taken while idle, no rsp
// Reset: synchronous, clears parser, pointers and the output valid; the
//   history memory is not cleared, a block only reads what it wrote.
// Stall: a stalled result holds in the output register; req_stall stays
//   high until the result slot can take the next transaction.
module lzss_rle_block_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [12:0] rsp_repeat_res,
   output logic        rsp_run_last,
   output logic        rsp_block_done,
   output logic        rsp_bad_reference
);

   localparam int AW = lzrle_pkg::HIST_AW;
   localparam int PW = lzrle_pkg::PROD_W;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COPY_RD = 4'b0010,
      ST_COPY_WR = 4'b0100,
      ST_FILL    = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [AW-1:0]                     wp_ff, wp_in;
   logic [PW-1:0]                     prod_ff, prod_in;
   logic [AW-1:0]                     src_ff, src_in;
   logic [lzrle_pkg::COPY_LEN_W-1:0]  copy_left_ff, copy_left_in;
   logic [lzrle_pkg::REPEAT_W-1:0]    fill_left_ff, fill_left_in;
   logic [7:0]                        fill_byte_ff, fill_byte_in;
   logic                              last_ff, last_in;
   logic [7:0]                        rd_data_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        out_byte_ff, out_byte_in;
   logic [12:0]                       repeat_ff, repeat_in;
   logic                              run_last_ff, run_last_in;
   logic                              done_ff, done_in;
   logic                              bad_ff, bad_in;

   lzrle_pkg::token_type              token;
   logic                              out_free;
   logic                              take;
   logic                              emit;
   logic                              mem_we;
   logic [7:0]                        mem_wdata;
   logic [AW-1:0]                     wp_inc;
   logic [PW-1:0]                     prod_inc;
   logic [AW-1:0]                     src_inc;
   logic [AW-1:0]                     copy_src;
   logic [AW:0]                       src_wrap;
   logic [AW-1:0]                     off_ext;
   logic                              bad_ref;

   logic [7:0]                        history [lzrle_pkg::WINDOW_DEPTH];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign take      = req_valid && !req_stall;

   lzrle_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .block_end (req_block_end),
      .token     (token)
   );

   // pointer arithmetic
   assign wp_inc   = (wp_ff == AW'(lzrle_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign prod_inc = (prod_ff < PW'(lzrle_pkg::WINDOW_DEPTH)) ? prod_ff + 1'b1 : prod_ff;
   assign src_inc  = (src_ff == AW'(lzrle_pkg::WINDOW_DEPTH - 1)) ? '0 : src_ff + 1'b1;
   assign off_ext  = AW'(token.offset);
   assign src_wrap = {1'b0, wp_ff} + (AW+1)'(lzrle_pkg::WINDOW_DEPTH) - {1'b0, off_ext};
   assign copy_src = (wp_ff >= off_ext) ? wp_ff - off_ext : src_wrap[AW-1:0];
   assign bad_ref  = PW'(token.offset) > prod_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      prod_in      = prod_ff;
      src_in       = src_ff;
      copy_left_in = copy_left_ff;
      fill_left_in = fill_left_ff;
      fill_byte_in = fill_byte_ff;
      last_in      = last_ff;
      emit         = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = req_data_byte;
      out_byte_in  = 8'd0;
      repeat_in    = 13'd0;
      run_last_in  = 1'b1;
      done_in      = 1'b0;
      bad_in       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               done_in = req_block_end;
               last_in = req_block_end;
               unique case (token.kind)
                  lzrle_pkg::TOK_LIT: begin
                     emit        = 1'b1;
                     mem_we      = 1'b1;
                     out_byte_in = req_data_byte;
                     repeat_in   = 13'd1;
                     wp_in       = wp_inc;
                     prod_in     = prod_inc;
                  end
                  lzrle_pkg::TOK_COPY: begin
                     if (bad_ref) begin
                        emit   = 1'b1;
                        bad_in = 1'b1;
                     end else begin
                        src_in       = copy_src;
                        copy_left_in = token.copy_len;
                        state_in     = ST_COPY_RD;
                     end
                  end
                  lzrle_pkg::TOK_RLE: begin
                     emit         = 1'b1;
                     out_byte_in  = req_data_byte;
                     repeat_in    = token.run_len;
                     fill_left_in = token.run_len;
                     fill_byte_in = req_data_byte;
                     if (!req_block_end) state_in = ST_FILL;
                  end
                  default: begin
                     // header or partial token: only the end marker
                     emit = req_block_end;
                  end
               endcase
               // block end with nothing left to do: restart pointers
               if (req_block_end && !(token.kind == lzrle_pkg::TOK_COPY && !bad_ref)) begin
                  wp_in   = '0;
                  prod_in = '0;
               end
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (out_free) begin
               emit         = 1'b1;
               mem_we       = 1'b1;
               mem_wdata    = rd_data_ff;
               out_byte_in  = rd_data_ff;
               repeat_in    = 13'd1;
               run_last_in  = (copy_left_ff == 5'd1);
               done_in      = (copy_left_ff == 5'd1) && last_ff;
               wp_in        = wp_inc;
               prod_in      = prod_inc;
               src_in       = src_inc;
               copy_left_in = copy_left_ff - 1'b1;
               if (copy_left_ff == 5'd1) begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     wp_in   = '0;
                     prod_in = '0;
                  end
               end else begin
                  state_in = ST_COPY_RD;
               end
            end
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            mem_wdata    = fill_byte_ff;
            wp_in        = wp_inc;
            prod_in      = prod_inc;
            fill_left_in = fill_left_ff - 1'b1;
            if (fill_left_ff == 13'd1) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register next valid
   always_comb begin
      if (emit) rsp_valid_in = 1'b1;
      else      rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         prod_ff      <= '0;
         copy_left_ff <= '0;
         fill_left_ff <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         prod_ff      <= prod_in;
         copy_left_ff <= copy_left_in;
         fill_left_ff <= fill_left_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      fill_byte_ff <= fill_byte_in;
      if (emit) begin
         out_byte_ff <= out_byte_in;
         repeat_ff   <= repeat_in;
         run_last_ff <= run_last_in;
         done_ff     <= done_in;
         bad_ff      <= bad_in;
      end
   end

   // history memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) history[wp_ff] <= mem_wdata;
      if (state_ff == ST_COPY_RD) rd_data_ff <= history[src_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_repeat_res    = repeat_ff;
   assign rsp_run_last      = run_last_ff;
   assign rsp_block_done    = done_ff;
   assign rsp_bad_reference = bad_ff;

   // input is held off while a copy or fill is running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken during copy or fill");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_RD || state_ff == ST_COPY_WR) |-> (copy_left_ff != '0))
      else $error("copy running with zero bytes left");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (fill_left_ff != '0))
      else $error("fill running with zero bytes left");

   assert property (@(posedge clock) disable iff (reset)
      prod_ff <= PW'(lzrle_pkg::WINDOW_DEPTH))
      else $error("produced count beyond window");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY_RD) |=> (state_ff == ST_COPY_WR))
      else $error("copy read not followed by write back");

endmodule
